// ===== sv/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes for the bounded deque: action and status codes and
// the command and result transaction structs.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // Action codes
  localparam logic [3:0] ACT_PUSH_FRONT  = 4'd0;
  localparam logic [3:0] ACT_PUSH_BACK   = 4'd1;
  localparam logic [3:0] ACT_POP_FRONT   = 4'd2;
  localparam logic [3:0] ACT_POP_BACK    = 4'd3;
  localparam logic [3:0] ACT_POP_BACK_K  = 4'd4;
  localparam logic [3:0] ACT_REMOVE_2ND  = 4'd5;
  localparam logic [3:0] ACT_APPEND_CNT  = 4'd6;
  localparam logic [3:0] ACT_APPEND_SEQ  = 4'd7;
  localparam logic [3:0] ACT_INS_B4_LAST = 4'd8;
  localparam logic [3:0] ACT_READ        = 4'd9;

  // Status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_IGNORED = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_RANGE   = 2'd3;

  // Command transaction
  typedef struct packed {
    logic [3:0]         action;
    logic signed [31:0] value;
    logic [12:0]        amount;
    logic [11:0]        position;
  } cmd_t;

  // Result transaction
  typedef struct packed {
    logic [1:0]         status;
    logic [12:0]        count;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic signed [31:0] read_value;
  } res_t;

endpackage

// ===== sv/bdq_ram.sv =====
// ----------------------------------------------------------------------------
// bdq_ram
// Ring storage: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_WIDTH-1:0]    wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_WIDTH-1:0]    rdata_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bounded_deque_with_edits_top.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_edits_top
// Bounded double-ended queue in a ring memory with head pointer and count.
// The result strobe is registered from an action's last state: execute, or
// read-wait or second-write when a ring read or a second write is needed
// (in-range reads, pops that leave entries, insert_before_last);
// append_sequence writes values in a sequence state. An item may be
// accepted in the cycle its result is shown; one ring access per cycle.
// Reset clears pointer, count and control; ring contents are not cleared.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module bounded_deque_with_edits_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  bdq_pkg::cmd_t cmd_i,
  output logic          done_o,
  output bdq_pkg::res_t res_o
);
  import bdq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_RDWT = 3'd2;
  localparam logic [2:0] ST_SEQ  = 3'd3;
  localparam logic [2:0] ST_INS2 = 3'd4;

  // Read data destinations
  localparam logic [1:0] DST_FRONT = 2'd0;
  localparam logic [1:0] DST_BACK  = 2'd1;
  localparam logic [1:0] DST_READ  = 2'd2;

  // Ring slot of an offset from the head
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(h) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // 32-bit input value to stored width
  function automatic logic [DATA_WIDTH-1:0] store_form(input logic signed [31:0] v);
    logic [63:0] e;
    e = 64'(v);
    return e[DATA_WIDTH-1:0];
  endfunction

  // Stored value to 32-bit output
  function automatic logic [31:0] out_form(input logic signed [DATA_WIDTH-1:0] x);
    logic [63:0] e;
    e = 64'(x);
    return e[31:0];
  endfunction

  logic [2:0]            state_q, state_d;
  logic [AW-1:0]         head_q, head_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0] front_q, front_d, back_q, back_d;
  cmd_t                  cmd_q, cmd_d;
  logic [12:0]           seq_q, seq_d;
  logic [AW-1:0]         addr_q, addr_d;
  logic [1:0]            dst_q, dst_d;
  res_t                  res_q, res_d;
  logic                  done_q;

  logic                  we, re, fin, full;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata, val_st, seq_st, cnt_st;
  logic [1:0]            fin_stat;
  logic [31:0]           fin_rd;
  logic [CW-1:0]         kcnt;

  bdq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign busy   = (state_q != ST_IDLE);
  assign full   = (cnt_q == CW'(DEPTH));
  assign val_st = store_form(cmd_q.value);
  assign seq_st = store_form(32'(seq_q));
  assign cnt_st = store_form(32'(cnt_q));
  assign kcnt   = (14'(cmd_q.amount) >= 14'(cnt_q)) ? '0 : cnt_q - CW'(cmd_q.amount);

  // Sequencer: read-modify-write of ring and pointers
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    cnt_d    = cnt_q;
    front_d  = front_q;
    back_d   = back_q;
    cmd_d    = cmd_q;
    seq_d    = seq_q;
    addr_d   = addr_q;
    dst_d    = dst_q;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    re       = 1'b0;
    raddr    = '0;
    fin      = 1'b0;
    fin_stat = STAT_OK;
    fin_rd   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_d   = cmd_i;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        unique case (cmd_q.action)
          ACT_PUSH_FRONT: begin
            fin = 1'b1;
            if (full) begin
              fin_stat = STAT_FULL;
            end else begin
              head_d  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
              we      = 1'b1;
              waddr   = head_d;
              wdata   = val_st;
              cnt_d   = cnt_q + CW'(1);
              front_d = val_st;
              if (cnt_q == '0) back_d = val_st;
            end
          end
          ACT_PUSH_BACK: begin
            fin = 1'b1;
            if (full) begin
              fin_stat = STAT_FULL;
            end else begin
              we     = 1'b1;
              waddr  = slot(head_q, cnt_q);
              wdata  = val_st;
              cnt_d  = cnt_q + CW'(1);
              back_d = val_st;
              if (cnt_q == '0) front_d = val_st;
            end
          end
          ACT_POP_FRONT: begin
            if (cnt_q == '0) begin
              fin      = 1'b1;
              fin_stat = STAT_IGNORED;
            end else begin
              head_d = slot(head_q, CW'(1));
              cnt_d  = cnt_q - CW'(1);
              if (cnt_q == CW'(1)) begin
                fin = 1'b1;
              end else begin
                re      = 1'b1;
                raddr   = slot(head_q, CW'(1));
                dst_d   = DST_FRONT;
                state_d = ST_RDWT;
              end
            end
          end
          ACT_POP_BACK: begin
            if (cnt_q == '0) begin
              fin      = 1'b1;
              fin_stat = STAT_IGNORED;
            end else begin
              cnt_d = cnt_q - CW'(1);
              if (cnt_q == CW'(1)) begin
                fin = 1'b1;
              end else begin
                re      = 1'b1;
                raddr   = slot(head_q, cnt_q - CW'(2));
                dst_d   = DST_BACK;
                state_d = ST_RDWT;
              end
            end
          end
          ACT_POP_BACK_K: begin
            if (cnt_q == '0) begin
              fin      = 1'b1;
              fin_stat = STAT_IGNORED;
            end else begin
              cnt_d = kcnt;
              if (kcnt == '0) begin
                fin = 1'b1;
              end else begin
                re      = 1'b1;
                raddr   = slot(head_q, kcnt - CW'(1));
                dst_d   = DST_BACK;
                state_d = ST_RDWT;
              end
            end
          end
          ACT_REMOVE_2ND: begin
            fin = 1'b1;
            if (cnt_q < CW'(2)) begin
              fin_stat = STAT_IGNORED;
            end else begin
              // old front moves into the second slot, which becomes the head
              we     = 1'b1;
              waddr  = slot(head_q, CW'(1));
              wdata  = front_q;
              head_d = slot(head_q, CW'(1));
              cnt_d  = cnt_q - CW'(1);
              if (cnt_q == CW'(2)) back_d = front_q;
            end
          end
          ACT_APPEND_CNT: begin
            fin = 1'b1;
            if (full) begin
              fin_stat = STAT_FULL;
            end else begin
              we     = 1'b1;
              waddr  = slot(head_q, cnt_q);
              wdata  = cnt_st;
              cnt_d  = cnt_q + CW'(1);
              back_d = cnt_st;
              if (cnt_q == '0) front_d = cnt_st;
            end
          end
          ACT_APPEND_SEQ: begin
            seq_d   = 13'd1;
            state_d = ST_SEQ;
          end
          ACT_INS_B4_LAST: begin
            if (cnt_q < CW'(2)) begin
              fin      = 1'b1;
              fin_stat = STAT_IGNORED;
            end else if (full) begin
              fin      = 1'b1;
              fin_stat = STAT_FULL;
            end else begin
              // copy last entry one slot on; value goes to old last slot next
              we      = 1'b1;
              waddr   = slot(head_q, cnt_q);
              wdata   = back_q;
              addr_d  = slot(head_q, cnt_q - CW'(1));
              cnt_d   = cnt_q + CW'(1);
              state_d = ST_INS2;
            end
          end
          ACT_READ: begin
            if (14'(cmd_q.position) >= 14'(cnt_q)) begin
              fin      = 1'b1;
              fin_stat = STAT_RANGE;
            end else begin
              re      = 1'b1;
              raddr   = slot(head_q, CW'(cmd_q.position));
              dst_d   = DST_READ;
              state_d = ST_RDWT;
            end
          end
          default: begin
            fin      = 1'b1;
            fin_stat = STAT_IGNORED;
          end
        endcase
      end

      ST_RDWT: begin
        fin = 1'b1;
        case (dst_q)
          DST_FRONT: front_d = rdata;
          DST_BACK:  back_d  = rdata;
          default:   fin_rd  = out_form(rdata);
        endcase
      end

      ST_SEQ: begin
        if (14'(seq_q) > 14'(cmd_q.amount)) begin
          fin = 1'b1;
        end else if (full) begin
          fin      = 1'b1;
          fin_stat = STAT_FULL;
        end else begin
          we     = 1'b1;
          waddr  = slot(head_q, cnt_q);
          wdata  = seq_st;
          cnt_d  = cnt_q + CW'(1);
          back_d = seq_st;
          if (cnt_q == '0) front_d = seq_st;
          seq_d  = seq_q + 13'd1;
        end
      end

      ST_INS2: begin
        fin   = 1'b1;
        we    = 1'b1;
        waddr = addr_q;
        wdata = val_st;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fin) begin
      state_d = ST_IDLE;
    end
  end

  // Result register built from the post-action state
  always_comb begin
    res_d.status      = fin_stat;
    res_d.count       = 13'(cnt_d);
    res_d.front_value = (cnt_d != '0) ? out_form(front_d) : '0;
    res_d.back_value  = (cnt_d != '0) ? out_form(back_d) : '0;
    res_d.read_value  = fin_rd;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      done_q  <= fin;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    back_q  <= back_d;
    cmd_q   <= cmd_d;
    seq_q   <= seq_d;
    addr_q  <= addr_d;
    dst_q   <= dst_d;
    if (fin) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= AW'(DEPTH - 1))
    else $error("head pointer out of ring");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while sequencer busy");

  a_no_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && re))
    else $error("ring read and write in the same cycle");

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded deque. Commands go in through the
// start/busy handshake, and each result strobe is compared field by field
// with an in-bench deque predictor. Directed tests cover the empty, short
// and full corner cases. Random traffic then runs under several sender gap
// rates.
// ----------------------------------------------------------------------------
module tb_top;
  import bdq_pkg::*;

  localparam int DEPTH          = 16;
  localparam int MAX_AMOUNT     = 4096;
  localparam int MAX_POSITION   = 4095;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;

  // Action codes the block does not define; they must come back ignored
  localparam logic [3:0] ACT_FIRST_UNUSED = ACT_READ + 4'd1;
  localparam logic [3:0] ACT_LAST_UNUSED  = 4'hF;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  cmd_t cmd_i;
  logic done_o;
  res_t res_o;

  // Predictor state: ring contents, head slot and entry count
  logic signed [31:0] dq_mem [DEPTH];
  int                 dq_head;
  int                 dq_cnt;

  res_t due_results [$];
  int   error_count;
  int   gap_pct;

  bounded_deque_with_edits_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Ring slot at an offset from the head
  function automatic int slot_of(int offset);
    return (dq_head + offset) % DEPTH;
  endfunction

  // Apply one command to the predictor and return the result it must produce
  task automatic apply_deque_action(input cmd_t c, output res_t r);
    int k;
    int last;
    r = '0;
    r.status = STAT_OK;
    case (c.action)
      ACT_PUSH_FRONT: begin
        if (dq_cnt >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          dq_head = (dq_head + DEPTH - 1) % DEPTH;
          dq_mem[dq_head] = c.value;
          dq_cnt++;
        end
      end
      ACT_PUSH_BACK: begin
        if (dq_cnt >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          dq_mem[slot_of(dq_cnt)] = c.value;
          dq_cnt++;
        end
      end
      ACT_POP_FRONT: begin
        if (dq_cnt == 0) begin
          r.status = STAT_IGNORED;
        end else begin
          dq_head = slot_of(1);
          dq_cnt--;
        end
      end
      ACT_POP_BACK: begin
        if (dq_cnt == 0) r.status = STAT_IGNORED;
        else dq_cnt--;
      end
      ACT_POP_BACK_K: begin
        if (dq_cnt == 0) r.status = STAT_IGNORED;
        else dq_cnt = (int'(c.amount) >= dq_cnt) ? 0 : dq_cnt - int'(c.amount);
      end
      ACT_REMOVE_2ND: begin
        if (dq_cnt < 2) begin
          r.status = STAT_IGNORED;
        end else begin
          dq_mem[slot_of(1)] = dq_mem[slot_of(0)];
          dq_head = slot_of(1);
          dq_cnt--;
        end
      end
      ACT_APPEND_CNT: begin
        if (dq_cnt >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          dq_mem[slot_of(dq_cnt)] = 32'(dq_cnt);
          dq_cnt++;
        end
      end
      ACT_APPEND_SEQ: begin
        // 1..k until the ring fills; a cut-short run reports full
        k = 1;
        while (k <= int'(c.amount) && r.status == STAT_OK) begin
          if (dq_cnt >= DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            dq_mem[slot_of(dq_cnt)] = 32'(k);
            dq_cnt++;
            k++;
          end
        end
      end
      ACT_INS_B4_LAST: begin
        if (dq_cnt < 2) begin
          r.status = STAT_IGNORED;
        end else if (dq_cnt >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          last = slot_of(dq_cnt - 1);
          dq_mem[slot_of(dq_cnt)] = dq_mem[last];
          dq_mem[last] = c.value;
          dq_cnt++;
        end
      end
      ACT_READ: begin
        if (int'(c.position) >= dq_cnt) r.status = STAT_RANGE;
        else r.read_value = dq_mem[slot_of(int'(c.position))];
      end
      default: r.status = STAT_IGNORED;
    endcase
    r.count = 13'(dq_cnt);
    if (dq_cnt != 0) begin
      r.front_value = dq_mem[slot_of(0)];
      r.back_value  = dq_mem[slot_of(dq_cnt - 1)];
    end
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, field, got, want);
    error_count++;
  endtask

  // Random data values, with the signed extremes weighted in
  function automatic logic signed [31:0] rand_value();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'sh7FFF_FFFF;
    if (r == 1) return 32'sh8000_0000;
    if (r == 2) return 32'($urandom_range(3));
    return 32'($urandom);
  endfunction

  // Random command; positions mostly land inside the current list
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   r;
    r = $urandom_range(99);
    if (r < 3) c.action = 4'($urandom_range(ACT_LAST_UNUSED, ACT_FIRST_UNUSED));
    else c.action = 4'($urandom_range(ACT_READ, ACT_PUSH_FRONT));
    c.value = rand_value();
    r = $urandom_range(99);
    if (r < 70) c.amount = 13'($urandom_range(6));
    else if (r < 85) c.amount = 13'($urandom_range(20));
    else if (r < 93) c.amount = 13'(MAX_AMOUNT);
    else c.amount = 13'($urandom_range(MAX_AMOUNT));
    if (dq_cnt > 0 && $urandom_range(3) != 0) c.position = 12'($urandom_range(dq_cnt - 1));
    else c.position = 12'($urandom_range(MAX_POSITION));
    return c;
  endfunction

  // Drive one command from a falling edge and hold it until accepted; the
  // sender may then go quiet for a while, with junk on the command bus
  task automatic send_cmd(input cmd_t c);
    res_t r;
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    apply_deque_action(c, r);
    due_results.push_back(r);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      cmd_i <= cmd_t'({$urandom, $urandom, $urandom});
      @(negedge clk_i);
    end
  endtask

  task automatic do_op(logic [3:0] action, logic signed [31:0] value = '0,
                       logic [12:0] amount = '0, logic [11:0] position = '0);
    cmd_t c;
    c.action   = action;
    c.value    = value;
    c.amount   = amount;
    c.position = position;
    send_cmd(c);
  endtask

  // Everything that must be ignored or out of range on an empty list
  task automatic test_empty_list();
    do_op(ACT_POP_FRONT);
    do_op(ACT_POP_BACK);
    do_op(ACT_POP_BACK_K, '0, 13'd1);
    do_op(ACT_INS_B4_LAST, 32'sd5);
    do_op(ACT_READ, '0, '0, 12'd0);
    do_op(ACT_FIRST_UNUSED);
    do_op(ACT_LAST_UNUSED);
  endtask

  // Edits on one- and two-entry lists, extreme values, read range edges
  task automatic test_short_list();
    do_op(ACT_PUSH_BACK, 32'sh7FFF_FFFF);
    do_op(ACT_REMOVE_2ND);
    do_op(ACT_INS_B4_LAST, 32'sd9);
    do_op(ACT_PUSH_FRONT, 32'sh8000_0000);
    do_op(ACT_INS_B4_LAST, -32'sd1);
    do_op(ACT_REMOVE_2ND);
    do_op(ACT_READ, '0, '0, 12'(MAX_POSITION));
    do_op(ACT_READ, '0, '0, 12'd1);
  endtask

  // Inserts against a full ring, then bulk pop past the count and appends
  task automatic test_full_ring();
    do_op(ACT_APPEND_SEQ, '0, 13'(MAX_AMOUNT));
    do_op(ACT_PUSH_FRONT, 32'sd1);
    do_op(ACT_PUSH_BACK, 32'sd2);
    do_op(ACT_APPEND_CNT);
    do_op(ACT_INS_B4_LAST, 32'sd3);
    do_op(ACT_APPEND_SEQ, '0, 13'd0);
    do_op(ACT_READ, '0, '0, 12'(DEPTH - 1));
    do_op(ACT_POP_BACK_K, '0, 13'(MAX_AMOUNT));
    do_op(ACT_APPEND_CNT);
    do_op(ACT_APPEND_SEQ, '0, 13'd3);
  endtask

  task automatic test_random_traffic(int n_items, int idle_pct);
    gap_pct = idle_pct;
    repeat (n_items) send_cmd(rand_cmd());
    gap_pct = 0;
  endtask

  // Result checker: every strobe must match the oldest expectation
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && done_o) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with nothing expected", $realtime);
        error_count++;
      end else begin
        want = due_results.pop_front();
        if (res_o.status !== want.status)
          report_mismatch("status", 32'(res_o.status), 32'(want.status));
        if (res_o.count !== want.count)
          report_mismatch("count", 32'(res_o.count), 32'(want.count));
        if (res_o.front_value !== want.front_value)
          report_mismatch("front_value", res_o.front_value, want.front_value);
        if (res_o.back_value !== want.back_value)
          report_mismatch("back_value", res_o.back_value, want.back_value);
        if (res_o.read_value !== want.read_value)
          report_mismatch("read_value", res_o.read_value, want.read_value);
      end
    end
  end

  // Watchdog: too many cycles with no transaction in either direction
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || done_o) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd_i       = '0;
    dq_head     = 0;
    dq_cnt      = 0;
    error_count = 0;
    gap_pct     = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_list();
    test_short_list();
    test_full_ring();
    // Results cannot be held off, so only the sender gap rate varies
    test_random_traffic(400, 0);
    test_random_traffic(400, 81);
    test_random_traffic(400, 16);

    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
